// File: hw/rtl/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg
// shared types, widths and register codes of the terrain pixel shader
// ----------------------------------------------------------------------------
package tps_pkg;

   // field widths
   localparam int HEIGHT_W    = 24;
   localparam int DIST_W      = 20;
   localparam int NORM_W      = 26;           // neighbour sum minus twice centre
   localparam int SQ_W        = 52;           // squared length of the normal
   localparam int ROOT_W      = SQ_W / 2;
   localparam int DOT_W       = 44;           // light . normal, signed
   localparam int DIFF_NUM_W  = DOT_W - 1;    // positive dot product
   localparam int FRAC_W      = 14;           // Q1.14 fraction bits
   localparam int LIGHT_W     = FRAC_W + 1;
   localparam int ONE_Q14     = 16384;
   localparam int NORMAL_Z    = 131;          // 0.0020 in Q8.16
   localparam int CH_NUM      = 3;
   localparam int P_W         = 8 + LIGHT_W;  // channel byte times light
   localparam int FOG_PROD_W  = P_W + DIST_W;
   localparam int FOG_X_W     = 29;           // blended value before the divide
   localparam int FOG_Q_W     = 8;

   // bands
   localparam int NUM_BANDS_DEF = 4;
   localparam int BAND_IDX_W    = 2;

   // register port
   localparam int CSR_W     = 64;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_DIR    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AMBIENT      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FOG_NEAR     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FOG_END      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FOG_COLOUR   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SKY_COLOUR   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_LIMITS  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_COLOURS = 3'd7;

   localparam logic [47:0] LIGHT_DIR_RST = 48'h4000_0000_0000;
   localparam logic [19:0] FOG_END_RST   = 20'hFFFFF;

   typedef struct packed {
      logic signed [HEIGHT_W-1:0] centre_height;
      logic signed [HEIGHT_W-1:0] left_height;
      logic signed [HEIGHT_W-1:0] right_height;
      logic signed [HEIGHT_W-1:0] above_height;
      logic signed [HEIGHT_W-1:0] below_height;
      logic [DIST_W-1:0]          ray_distance;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

   // per-pixel side information that rides along the pipeline
   typedef struct packed {
      logic                  sky;
      logic [BAND_IDX_W-1:0] band;
      logic [DIST_W-1:0]     fog_num;
      logic [DIST_W-1:0]     fog_den;
   } pix_tag_type;

   typedef struct packed {
      logic signed [DOT_W-1:0] dot;
      pix_tag_type             pix;
   } sqrt_tag_type;

   typedef struct packed {
      logic        sat;
      pix_tag_type pix;
   } diff_tag_type;

endpackage

// File: hw/rtl/tps_front.sv
// ----------------------------------------------------------------------------
// tps_front
// normal, band pick, fog terms, squared length and light dot product
// ----------------------------------------------------------------------------
module tps_front #(
   parameter int NUM_BANDS = tps_pkg::NUM_BANDS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  tps_pkg::req_type                  req,
   input  logic [47:0]                       light_dir,
   input  logic [tps_pkg::DIST_W-1:0]        fog_near,
   input  logic [tps_pkg::DIST_W-1:0]        fog_end,
   input  logic [63:0]                       band_limits,
   output logic                              out_valid,
   output logic [tps_pkg::SQ_W-1:0]          out_sum,
   output logic signed [tps_pkg::DOT_W-1:0]  out_dot,
   output tps_pkg::pix_tag_type              out_tag
);

   localparam int NW = tps_pkg::NORM_W;

   logic [2:0] vld_ff;

   // stage 1
   logic signed [NW-1:0] nx_in, ny_in, nx_ff, ny_ff;
   tps_pkg::pix_tag_type tag1_in, tag1_ff;

   // stage 2
   logic signed [2*NW-1:0] sqx_in, sqy_in, sqx_ff, sqy_ff;
   logic signed [16+NW-1:0] px_in, py_in, px_ff, py_ff;
   logic signed [23:0] pz_in, pz_ff;
   tps_pkg::pix_tag_type tag2_ff;

   // stage 3
   logic [tps_pkg::SQ_W-1:0] sum_in, sum_ff;
   logic signed [tps_pkg::DOT_W-1:0] dot_in, dot_ff;
   tps_pkg::pix_tag_type tag3_ff;

   logic signed [15:0] lx, ly, lz;

   always_comb begin
      nx_in = NW'(req.left_height) + NW'(req.right_height) - (NW'(req.centre_height) <<< 1);
      ny_in = NW'(req.above_height) + NW'(req.below_height) - (NW'(req.centre_height) <<< 1);
      tag1_in.sky = req.ray_distance > fog_end;
      if (req.ray_distance > fog_near) begin
         tag1_in.fog_num = req.ray_distance - fog_near;
         tag1_in.fog_den = fog_end - fog_near;
      end else begin
         tag1_in.fog_num = '0;
         tag1_in.fog_den = tps_pkg::DIST_W'(1);
      end
      // first band whose limit is not above the centre height
      tag1_in.band = tps_pkg::BAND_IDX_W'(NUM_BANDS - 1);
      for (int k = NUM_BANDS - 1; k >= 0; k--) begin
         if (req.centre_height >= $signed({band_limits[16*k +: 16], 8'h00}))
            tag1_in.band = tps_pkg::BAND_IDX_W'(k);
      end
   end

   assign lx = $signed(light_dir[15:0]);
   assign ly = $signed(light_dir[31:16]);
   assign lz = $signed(light_dir[47:32]);

   always_comb begin
      sqx_in = nx_ff * nx_ff;
      sqy_in = ny_ff * ny_ff;
      px_in  = lx * nx_ff;
      py_in  = ly * ny_ff;
      pz_in  = lz * $signed(10'(tps_pkg::NORMAL_Z));
   end

   always_comb begin
      sum_in = tps_pkg::SQ_W'(sqx_ff) + tps_pkg::SQ_W'(sqy_ff)
             + tps_pkg::SQ_W'(tps_pkg::NORMAL_Z * tps_pkg::NORMAL_Z);
      dot_in = tps_pkg::DOT_W'(px_ff) + tps_pkg::DOT_W'(py_ff) + tps_pkg::DOT_W'(pz_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      nx_ff   <= nx_in;
      ny_ff   <= ny_in;
      tag1_ff <= tag1_in;
      sqx_ff  <= sqx_in;
      sqy_ff  <= sqy_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      pz_ff   <= pz_in;
      tag2_ff <= tag1_ff;
      sum_ff  <= sum_in;
      dot_ff  <= dot_in;
      tag3_ff <= tag2_ff;
   end

   assign out_valid = vld_ff[2];
   assign out_sum   = sum_ff;
   assign out_dot   = dot_ff;
   assign out_tag   = tag3_ff;

endmodule

// File: hw/rtl/tps_isqrt.sv
// ----------------------------------------------------------------------------
// tps_isqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module tps_isqrt #(
   parameter int RAD_W = tps_pkg::SQ_W,
   parameter int TAG_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [RAD_W-1:0]     in_rad,
   input  logic [TAG_W-1:0]     in_tag,
   output logic                 out_valid,
   output logic [RAD_W/2-1:0]   out_root,
   output logic [TAG_W-1:0]     out_tag
);

   localparam int STEPS = RAD_W / 2;

   logic [STEPS-1:0] vld_ff;
   logic [RAD_W-1:0] rem_ff [STEPS];
   logic [RAD_W-1:0] res_ff [STEPS];
   logic [TAG_W-1:0] tag_ff [STEPS];
   logic [RAD_W-1:0] rem_cur [STEPS];
   logic [RAD_W-1:0] res_cur [STEPS];
   logic [TAG_W-1:0] tag_cur [STEPS];
   logic [RAD_W-1:0] rem_in [STEPS];
   logic [RAD_W-1:0] res_in [STEPS];

   always_comb begin
      logic [RAD_W-1:0] bit_val;
      logic [RAD_W-1:0] trial;
      rem_cur[0] = in_rad;
      res_cur[0] = '0;
      tag_cur[0] = in_tag;
      for (int i = 1; i < STEPS; i++) begin
         rem_cur[i] = rem_ff[i-1];
         res_cur[i] = res_ff[i-1];
         tag_cur[i] = tag_ff[i-1];
      end
      for (int i = 0; i < STEPS; i++) begin
         bit_val = RAD_W'(1) << (RAD_W - 2 - 2*i);
         trial   = res_cur[i] + bit_val;
         if (rem_cur[i] >= trial) begin
            rem_in[i] = rem_cur[i] - trial;
            res_in[i] = (res_cur[i] >> 1) + bit_val;
         end else begin
            rem_in[i] = rem_cur[i];
            res_in[i] = res_cur[i] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[STEPS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < STEPS; i++) begin
         rem_ff[i] <= rem_in[i];
         res_ff[i] <= res_in[i];
         tag_ff[i] <= tag_cur[i];
      end
   end

   assign out_valid = vld_ff[STEPS-1];
   assign out_root  = res_ff[STEPS-1][RAD_W/2-1:0];
   assign out_tag   = tag_ff[STEPS-1];

endmodule

// File: hw/rtl/tps_div.sv
// ----------------------------------------------------------------------------
// tps_div
// pipelined restoring divider, one quotient bit per stage, several lanes
// ----------------------------------------------------------------------------
module tps_div #(
   parameter int NUM_W = tps_pkg::DIFF_NUM_W,
   parameter int DEN_W = tps_pkg::ROOT_W,
   parameter int QUO_W = tps_pkg::FRAC_W,
   parameter int LANES = 1,
   parameter int TAG_W = 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic [LANES-1:0][NUM_W-1:0]      in_num,
   input  logic [LANES-1:0][DEN_W-1:0]      in_den,
   input  logic [TAG_W-1:0]                 in_tag,
   output logic                             out_valid,
   output logic [LANES-1:0][QUO_W-1:0]      out_quo,
   output logic [TAG_W-1:0]                 out_tag
);

   // quotient must fit QUO_W bits: num < den << QUO_W
   localparam int CW = NUM_W + DEN_W;

   logic [QUO_W-1:0] vld_ff;
   logic [LANES-1:0][NUM_W-1:0] rem_ff [QUO_W];
   logic [LANES-1:0][DEN_W-1:0] den_ff [QUO_W];
   logic [LANES-1:0][QUO_W-1:0] quo_ff [QUO_W];
   logic [TAG_W-1:0]            tag_ff [QUO_W];
   logic [LANES-1:0][NUM_W-1:0] rem_cur [QUO_W];
   logic [LANES-1:0][DEN_W-1:0] den_cur [QUO_W];
   logic [LANES-1:0][QUO_W-1:0] quo_cur [QUO_W];
   logic [TAG_W-1:0]            tag_cur [QUO_W];
   logic [LANES-1:0][NUM_W-1:0] rem_in [QUO_W];
   logic [LANES-1:0][QUO_W-1:0] quo_in [QUO_W];

   always_comb begin
      logic [CW-1:0] shifted;
      rem_cur[0] = in_num;
      den_cur[0] = in_den;
      quo_cur[0] = '0;
      tag_cur[0] = in_tag;
      for (int i = 1; i < QUO_W; i++) begin
         rem_cur[i] = rem_ff[i-1];
         den_cur[i] = den_ff[i-1];
         quo_cur[i] = quo_ff[i-1];
         tag_cur[i] = tag_ff[i-1];
      end
      for (int i = 0; i < QUO_W; i++) begin
         for (int l = 0; l < LANES; l++) begin
            shifted = CW'(den_cur[i][l]) << (QUO_W - 1 - i);
            if (CW'(rem_cur[i][l]) >= shifted) begin
               rem_in[i][l] = rem_cur[i][l] - NUM_W'(shifted);
               quo_in[i][l] = {quo_cur[i][l][QUO_W-2:0], 1'b1};
            end else begin
               rem_in[i][l] = rem_cur[i][l];
               quo_in[i][l] = {quo_cur[i][l][QUO_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[QUO_W-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUO_W; i++) begin
         rem_ff[i] <= rem_in[i];
         den_ff[i] <= den_cur[i];
         quo_ff[i] <= quo_in[i];
         tag_ff[i] <= tag_cur[i];
      end
   end

   assign out_valid = vld_ff[QUO_W-1];
   assign out_quo   = quo_ff[QUO_W-1];
   assign out_tag   = tag_ff[QUO_W-1];

endmodule

// File: hw/rtl/terrain_pixel_shader.sv
// ----------------------------------------------------------------------------
// terrain_pixel_shader
// lambert diffuse shading of one height-map pixel with height bands and fog
// ----------------------------------------------------------------------------
// depth: 58 register stages from start to rsp_strobe
// throughput: one request per clock, busy stays low, results are never held back
// depth is set by the 26-step square root, the 14-step diffuse divide and the
// 8-step fog divide, all fully pipelined
// reset: synchronous, clears the pipeline valid bits and loads register defaults
// ----------------------------------------------------------------------------
module terrain_pixel_shader #(
   parameter int NUM_BANDS = tps_pkg::NUM_BANDS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  tps_pkg::req_type                 req_data,
   output logic                             rsp_strobe,
   output tps_pkg::rsp_type                 rsp_data,
   input  logic                             csr_write_en,
   input  logic [tps_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tps_pkg::CSR_W-1:0]        csr_wdata
);

   localparam int FRAC = tps_pkg::FRAC_W;
   localparam int LW   = tps_pkg::LIGHT_W;
   localparam int DW   = tps_pkg::DIST_W;
   localparam int CH   = tps_pkg::CH_NUM;

   // ---------------------------------------------------------------- registers
   logic [47:0]  light_dir_ff;
   logic [8:0]   ambient_ff;
   logic [DW-1:0] fog_near_ff, fog_end_ff;
   logic [23:0]  fog_colour_ff, sky_colour_ff;
   logic [63:0]  band_limits_ff, band_colours_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         light_dir_ff    <= tps_pkg::LIGHT_DIR_RST;
         ambient_ff      <= '0;
         fog_near_ff     <= '0;
         fog_end_ff      <= tps_pkg::FOG_END_RST;
         fog_colour_ff   <= '0;
         sky_colour_ff   <= '0;
         band_limits_ff  <= '0;
         band_colours_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            tps_pkg::CSR_LIGHT_DIR:    light_dir_ff    <= csr_wdata[47:0];
            tps_pkg::CSR_AMBIENT:      ambient_ff      <= csr_wdata[8:0];
            tps_pkg::CSR_FOG_NEAR:     fog_near_ff     <= csr_wdata[DW-1:0];
            tps_pkg::CSR_FOG_END:      fog_end_ff      <= csr_wdata[DW-1:0];
            tps_pkg::CSR_FOG_COLOUR:   fog_colour_ff   <= csr_wdata[23:0];
            tps_pkg::CSR_SKY_COLOUR:   sky_colour_ff   <= csr_wdata[23:0];
            tps_pkg::CSR_BAND_LIMITS:  band_limits_ff  <= csr_wdata;
            tps_pkg::CSR_BAND_COLOURS: band_colours_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // the pipeline never stalls, so every request is taken
   assign busy = 1'b0;

   // ---------------------------------------------------------------- front end
   // normal, squared length, dot product, band and fog distances
   logic                                fr_vld;
   logic [tps_pkg::SQ_W-1:0]            fr_sum;
   logic signed [tps_pkg::DOT_W-1:0]    fr_dot;
   tps_pkg::pix_tag_type                fr_tag;

   tps_front #(.NUM_BANDS(NUM_BANDS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (start),
      .req         (req_data),
      .light_dir   (light_dir_ff),
      .fog_near    (fog_near_ff),
      .fog_end     (fog_end_ff),
      .band_limits (band_limits_ff),
      .out_valid   (fr_vld),
      .out_sum     (fr_sum),
      .out_dot     (fr_dot),
      .out_tag     (fr_tag)
   );

   // ---------------------------------------------------------------- normal length
   tps_pkg::sqrt_tag_type               sq_tag_in, sq_tag;
   logic                                sq_vld;
   logic [tps_pkg::ROOT_W-1:0]          sq_root;

   always_comb begin
      sq_tag_in.dot = fr_dot;
      sq_tag_in.pix = fr_tag;
   end

   tps_isqrt #(
      .RAD_W (tps_pkg::SQ_W),
      .TAG_W ($bits(tps_pkg::sqrt_tag_type))
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_vld),
      .in_rad    (fr_sum),
      .in_tag    (sq_tag_in),
      .out_valid (sq_vld),
      .out_root  (sq_root),
      .out_tag   (sq_tag)
   );

   // ---------------------------------------------------------------- diffuse setup
   // a dot product at or above 1.0 times the length saturates, a non-positive
   // one gives no diffuse light; otherwise the quotient fits 14 bits
   logic                                 pre_vld_ff;
   logic [tps_pkg::DIFF_NUM_W-1:0]       pre_num_in, pre_num_ff;
   logic [tps_pkg::ROOT_W-1:0]           pre_den_ff;
   tps_pkg::diff_tag_type                pre_tag_in, pre_tag_ff;
   logic                                 dot_pos;

   always_comb begin
      dot_pos = sq_tag.dot > $signed(tps_pkg::DOT_W'(0));
      pre_tag_in.pix = sq_tag.pix;
      pre_tag_in.sat = dot_pos
         && (sq_tag.dot[tps_pkg::DIFF_NUM_W-1:0] >= tps_pkg::DIFF_NUM_W'({sq_root, FRAC'(0)}));
      pre_num_in = (dot_pos && !pre_tag_in.sat) ? sq_tag.dot[tps_pkg::DIFF_NUM_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_vld_ff <= 1'b0;
      end else begin
         pre_vld_ff <= sq_vld;
      end
   end

   always_ff @(posedge clock) begin
      pre_num_ff <= pre_num_in;
      pre_den_ff <= sq_root;
      pre_tag_ff <= pre_tag_in;
   end

   // ---------------------------------------------------------------- diffuse divide
   logic                                 df_vld;
   logic [0:0][FRAC-1:0]                 df_quo;
   tps_pkg::diff_tag_type                df_tag;

   tps_div #(
      .NUM_W (tps_pkg::DIFF_NUM_W),
      .DEN_W (tps_pkg::ROOT_W),
      .QUO_W (FRAC),
      .LANES (1),
      .TAG_W ($bits(tps_pkg::diff_tag_type))
   ) u_diff_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pre_vld_ff),
      .in_num    (pre_num_ff),
      .in_den    (pre_den_ff),
      .in_tag    (pre_tag_ff),
      .out_valid (df_vld),
      .out_quo   (df_quo),
      .out_tag   (df_tag)
   );

   // ---------------------------------------------------------------- light
   // light = amb + diff * (1 - amb), amb clamped to 1.0
   logic                     l1_vld_ff, l2_vld_ff;
   logic [LW-1:0]            diff_val, amb_in, amb_ff;
   logic [2*LW-1:0]          prod_in, prod_ff;
   tps_pkg::pix_tag_type     l1_tag_ff, l2_tag_ff;
   logic [LW:0]              light_sum;
   logic [LW-1:0]            light_in, light_ff;

   always_comb begin
      diff_val = df_tag.sat ? LW'(tps_pkg::ONE_Q14) : {1'b0, df_quo[0]};
      amb_in   = (ambient_ff > 9'd256) ? LW'(tps_pkg::ONE_Q14) : LW'({ambient_ff, 6'b0});
      prod_in  = diff_val * (LW'(tps_pkg::ONE_Q14) - amb_in);
   end

   always_comb begin
      light_sum = (LW+1)'(amb_ff) + (LW+1)'(prod_ff[2*LW-1:FRAC]);
      light_in  = (light_sum > (LW+1)'(tps_pkg::ONE_Q14)) ? LW'(tps_pkg::ONE_Q14)
                                                         : light_sum[LW-1:0];
   end

   // ---------------------------------------------------------------- band colour
   // rgb565 widened by bit replication, then scaled by the light
   logic [15:0]                         rgb565;
   logic [CH-1:0][7:0]                  band_c8;
   logic [CH-1:0][tps_pkg::P_W-1:0]     shade_in, shade_ff;
   logic                                c1_vld_ff, c2_vld_ff, c3_vld_ff;
   tps_pkg::pix_tag_type                c1_tag_ff, c2_tag_ff;

   always_comb begin
      rgb565     = band_colours_ff[16*l2_tag_ff.band +: 16];
      band_c8[0] = {rgb565[15:11], rgb565[15:13]};
      band_c8[1] = {rgb565[10:5],  rgb565[10:9]};
      band_c8[2] = {rgb565[4:0],   rgb565[4:2]};
      for (int c = 0; c < CH; c++)
         shade_in[c] = band_c8[c] * light_ff;
   end

   // ---------------------------------------------------------------- fog blend
   // x = (p * (d - n) + (f << 14) * n) >> 14, divided by d later;
   // without fog n = 0 and d = 1, which leaves p >> 14
   logic [DW-1:0]                             fog_w;
   logic [CH-1:0][7:0]                        fog_c8;
   logic [CH-1:0][tps_pkg::FOG_PROD_W-1:0]    pw_in, pw_ff;
   logic [CH-1:0][8+DW-1:0]                   fn_in, fn_ff;
   logic [CH-1:0][tps_pkg::FOG_PROD_W:0]      blend_sum;
   logic [CH-1:0][tps_pkg::FOG_X_W-1:0]       fog_x_in, fog_x_ff;
   logic [DW-1:0]                             fog_den_ff;
   logic                                      c3_sky_ff;

   always_comb begin
      fog_w     = c1_tag_ff.fog_den - c1_tag_ff.fog_num;
      fog_c8[0] = fog_colour_ff[23:16];
      fog_c8[1] = fog_colour_ff[15:8];
      fog_c8[2] = fog_colour_ff[7:0];
      for (int c = 0; c < CH; c++) begin
         pw_in[c] = shade_ff[c] * fog_w;
         fn_in[c] = fog_c8[c] * c1_tag_ff.fog_num;
      end
   end

   always_comb begin
      for (int c = 0; c < CH; c++) begin
         blend_sum[c] = (tps_pkg::FOG_PROD_W+1)'(pw_ff[c])
                      + (tps_pkg::FOG_PROD_W+1)'({fn_ff[c], FRAC'(0)});
         fog_x_in[c]  = blend_sum[c][FRAC +: tps_pkg::FOG_X_W];
      end
   end

   // ---------------------------------------------------------------- light / colour pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         l1_vld_ff <= 1'b0;
         l2_vld_ff <= 1'b0;
         c1_vld_ff <= 1'b0;
         c2_vld_ff <= 1'b0;
         c3_vld_ff <= 1'b0;
      end else begin
         l1_vld_ff <= df_vld;
         l2_vld_ff <= l1_vld_ff;
         c1_vld_ff <= l2_vld_ff;
         c2_vld_ff <= c1_vld_ff;
         c3_vld_ff <= c2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      amb_ff     <= amb_in;
      prod_ff    <= prod_in;
      l1_tag_ff  <= df_tag.pix;
      light_ff   <= light_in;
      l2_tag_ff  <= l1_tag_ff;
      shade_ff   <= shade_in;
      c1_tag_ff  <= l2_tag_ff;
      pw_ff      <= pw_in;
      fn_ff      <= fn_in;
      c2_tag_ff  <= c1_tag_ff;
      fog_x_ff   <= fog_x_in;
      fog_den_ff <= c2_tag_ff.fog_den;
      c3_sky_ff  <= c2_tag_ff.sky;
   end

   // ---------------------------------------------------------------- fog divide
   logic                              fd_vld;
   logic [CH-1:0][tps_pkg::FOG_Q_W-1:0] fd_quo;
   logic [0:0]                        fd_sky;

   tps_div #(
      .NUM_W (tps_pkg::FOG_X_W),
      .DEN_W (DW),
      .QUO_W (tps_pkg::FOG_Q_W),
      .LANES (CH),
      .TAG_W (1)
   ) u_fog_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c3_vld_ff),
      .in_num    (fog_x_ff),
      .in_den    ({CH{fog_den_ff}}),
      .in_tag    (c3_sky_ff),
      .out_valid (fd_vld),
      .out_quo   (fd_quo),
      .out_tag   (fd_sky)
   );

   // ---------------------------------------------------------------- result register
   // sky pixels take the sky colour unchanged
   logic              rsp_strobe_ff;
   tps_pkg::rsp_type  rsp_data_in, rsp_data_ff;

   always_comb begin
      if (fd_sky[0]) begin
         rsp_data_in.red   = sky_colour_ff[23:16];
         rsp_data_in.green = sky_colour_ff[15:8];
         rsp_data_in.blue  = sky_colour_ff[7:0];
      end else begin
         rsp_data_in.red   = fd_quo[0];
         rsp_data_in.green = fd_quo[1];
         rsp_data_in.blue  = fd_quo[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= fd_vld;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // ---------------------------------------------------------------- assertions
   // diffuse quotient must fit 14 bits unless saturated
   a_diff_fits: assert property (@(posedge clock) disable iff (reset)
      pre_vld_ff && !pre_tag_ff.sat
         |-> (pre_num_ff < tps_pkg::DIFF_NUM_W'({pre_den_ff, FRAC'(0)})))
      else $error("diffuse quotient overflows");

   // total light never above 1.0
   a_light_max: assert property (@(posedge clock) disable iff (reset)
      l2_vld_ff |-> (light_ff <= LW'(tps_pkg::ONE_Q14)))
      else $error("light above one");

   // fog quotient must fit one byte for non-sky pixels
   a_fog_fits: assert property (@(posedge clock) disable iff (reset)
      c3_vld_ff && !c3_sky_ff
         |-> (fog_x_ff[0] < tps_pkg::FOG_X_W'({fog_den_ff, 8'h00}))
          && (fog_x_ff[1] < tps_pkg::FOG_X_W'({fog_den_ff, 8'h00}))
          && (fog_x_ff[2] < tps_pkg::FOG_X_W'({fog_den_ff, 8'h00})))
      else $error("fog quotient overflows");

endmodule

// File: tb/sv/tb_terrain_pixel_shader.sv
// ----------------------------------------------------------------------------
// tb_terrain_pixel_shader
// self-checking bench: random and directed pixels through the shader, each
// response checked against an in-bench model of the shading arithmetic
// ----------------------------------------------------------------------------
module tb_terrain_pixel_shader;
   timeunit 1ns;
   timeprecision 1ps;
   import tps_pkg::*;

   localparam int PIPE_LAT = 58;

   // scoreboard: shading model plus queue of pending pixel colours
   class shade_board;
      logic [47:0] light_dir;
      logic [8:0]  ambient;
      logic [19:0] fog_lo, fog_hi;
      logic [23:0] fog_rgb, sky_rgb;
      logic [63:0] limits, colours;
      rsp_type     pending[$];
      int          errors;

      function new();
         light_dir = LIGHT_DIR_RST; ambient = 0; fog_lo = 0; fog_hi = FOG_END_RST;
         fog_rgb = 0; sky_rgb = 0; limits = 0; colours = 0; errors = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [63:0] v);
         case (idx)
            CSR_LIGHT_DIR:    light_dir = v[47:0];
            CSR_AMBIENT:      ambient = v[8:0];
            CSR_FOG_NEAR:     fog_lo = v[19:0];
            CSR_FOG_END:      fog_hi = v[19:0];
            CSR_FOG_COLOUR:   fog_rgb = v[23:0];
            CSR_SKY_COLOUR:   sky_rgb = v[23:0];
            CSR_BAND_LIMITS:  limits = v;
            CSR_BAND_COLOURS: colours = v;
            default: ;
         endcase
      endfunction

      function longint unsigned root(longint unsigned x);
         longint unsigned r, b;
         r = 0; b = 64'd1 << 62;
         while (b > x) b >>= 2;
         while (b != 0) begin
            if (x >= r + b) begin
               x -= r + b; r = (r >> 1) + b;
            end else r >>= 1;
            b >>= 2;
         end
         return r;
      endfunction

      // note an accepted request: compute its colour
      function void note_request(req_type q);
         longint c, nx, ny, lx, ly, lz, dot, diff, amb, lt, lim;
         longint unsigned mag, num, den, p, v;
         logic [15:0] rgb;
         logic [7:0] ch[3], fc[3];
         int band;
         rsp_type e;
         if (q.ray_distance > fog_hi) begin
            e = sky_rgb; pending.push_back(e); return;
         end
         c = q.centre_height;
         nx = longint'(q.left_height) + q.right_height - 2 * c;
         ny = longint'(q.above_height) + q.below_height - 2 * c;
         mag = root(nx * nx + ny * ny + NORMAL_Z * NORMAL_Z);
         lx = $signed(light_dir[15:0]); ly = $signed(light_dir[31:16]);
         lz = $signed(light_dir[47:32]);
         dot = lx * nx + ly * ny + lz * NORMAL_Z;
         diff = 0;
         if (dot > 0 && mag != 0) begin
            diff = dot / longint'(mag);
            if (diff > ONE_Q14) diff = ONE_Q14;
         end
         amb = (ambient > 256 ? 256 : ambient) << 6;
         lt = amb + (diff * (ONE_Q14 - amb)) / ONE_Q14;
         if (lt > ONE_Q14) lt = ONE_Q14;
         band = 3;
         for (int k = 0; k < 4; k++) begin
            lim = longint'($signed(limits[16*k +: 16])) * 256;
            if (!(lim > c)) begin
               band = k; break;
            end
         end
         rgb = colours[16*band +: 16];
         ch[0] = {rgb[15:11], rgb[15:13]};
         ch[1] = {rgb[10:5], rgb[10:9]};
         ch[2] = {rgb[4:0], rgb[4:2]};
         fc[0] = fog_rgb[23:16]; fc[1] = fog_rgb[15:8]; fc[2] = fog_rgb[7:0];
         if (q.ray_distance > fog_lo) begin
            num = q.ray_distance - fog_lo; den = fog_hi - fog_lo;
         end else begin
            num = 0; den = 1;
         end
         for (int i = 0; i < 3; i++) begin
            p = ch[i] * longint'(lt);
            v = (p * (den - num) + (longint'(fc[i]) << 14) * num) / (den << 14);
            ch[i] = v[7:0];
         end
         e.red = ch[0]; e.green = ch[1]; e.blue = ch[2];
         pending.push_back(e);
      endfunction

      function void report(string what);
         $display("mismatch: %s", what);
         errors++;
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            report($sformatf("unexpected response %h", got)); return;
         end
         e = pending.pop_front();
         if (got.red != e.red) report($sformatf("red %h want %h", got.red, e.red));
         if (got.green != e.green)
            report($sformatf("green %h want %h", got.green, e.green));
         if (got.blue != e.blue) report($sformatf("blue %h want %h", got.blue, e.blue));
      endfunction
   endclass

   logic        clock, reset, start, busy, rsp_strobe, csr_write_en;
   req_type     req_data;
   rsp_type     rsp_data;
   logic [2:0]  csr_index;
   logic [63:0] csr_wdata;
   shade_board  sb;

   terrain_pixel_shader uut (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // hard stop well past the slowest legal run
   initial begin
      #5ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // response monitor, sampled at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_response(rsp_data);
   end

   // driven at the falling edge, so the block sees stable values at the next rise
   task automatic write_csr(logic [2:0] idx, logic [63:0] v);
      csr_write_en = 1; csr_index = idx; csr_wdata = v;
      @(negedge clock);
      csr_write_en = 0;
      sb.write_reg(idx, v);
   endtask

   // wait for pipeline to drain before touching registers
   task automatic drain();
      int n;
      n = 0;
      while (sb.pending.size() != 0 && n < 20000) begin
         @(negedge clock); n++;
      end
      repeat (PIPE_LAT + 4) @(negedge clock);
   endtask

   // send one request; holds start across back-to-back requests
   task automatic send_request(req_type q, bit keep);
      start = 1; req_data = q;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(q);
      @(negedge clock);
      if (!keep) start = 0;
   endtask

   function automatic logic [23:0] rnd_height(int mode);
      case (mode)
         0: return 24'h800000;
         1: return 24'h7FFFFF;
         2: return 24'($urandom_range(0, 2047)) - 24'd1024;
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic req_type rnd_request();
      req_type q;
      int m;
      m = $urandom_range(0, 9);
      q.centre_height = (m == 0) ? rnd_height($urandom_range(0, 1)) : 24'($urandom);
      if (m < 5) begin
         // smooth surface: neighbours near centre
         q.left_height  = q.centre_height + rnd_height(2);
         q.right_height = q.centre_height + rnd_height(2);
         q.above_height = q.centre_height + rnd_height(2);
         q.below_height = q.centre_height + rnd_height(2);
      end else begin
         q.left_height  = rnd_height($urandom_range(0, 3));
         q.right_height = rnd_height($urandom_range(0, 3));
         q.above_height = rnd_height($urandom_range(0, 3));
         q.below_height = rnd_height($urandom_range(0, 3));
      end
      q.ray_distance = 20'($urandom);
      return q;
   endfunction

   // random register set, every register touched
   task automatic random_setting(int kind);
      logic [19:0] a, b;
      a = 20'($urandom); b = 20'($urandom);
      if (a > b) {a, b} = {b, a};
      write_csr(CSR_LIGHT_DIR, kind == 0 ? 64'h4000_0000_0000 : {$urandom, $urandom});
      write_csr(CSR_AMBIENT, kind == 1 ? 64'h1FF : 64'($urandom_range(0, 300)));
      write_csr(CSR_FOG_NEAR, kind == 2 ? 64'h0 : 64'(a));
      write_csr(CSR_FOG_END, kind == 2 ? 64'hFFFFF : 64'(b));
      write_csr(CSR_FOG_COLOUR, 64'($urandom));
      write_csr(CSR_SKY_COLOUR, kind == 3 ? 64'hFFFFFF : 64'($urandom));
      write_csr(CSR_BAND_LIMITS, {$urandom, $urandom});
      write_csr(CSR_BAND_COLOURS, kind == 3 ? '1 : {$urandom, $urandom});
   endtask

   initial begin
      req_type q;
      int burst;
      sb = new();
      reset = 1; start = 0; req_data = '0;
      csr_write_en = 0; csr_index = CSR_LIGHT_DIR; csr_wdata = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: reset settings, flat and extreme surfaces
      q = '0;
      send_request(q, 0);
      q.centre_height = 24'h800000; q.left_height = 24'h7FFFFF; q.right_height = 24'h7FFFFF;
      q.above_height = 24'h7FFFFF; q.below_height = 24'h7FFFFF; q.ray_distance = 20'hFFFFF;
      send_request(q, 1);
      q.centre_height = 24'h7FFFFF; q.left_height = 24'h800000; q.right_height = 24'h800000;
      q.above_height = 24'h800000; q.below_height = 24'h800000; q.ray_distance = 0;
      send_request(q, 0);
      drain();

      // directed: sky boundary, fog edges, all bands, full ambient
      write_csr(CSR_FOG_NEAR, 64'd1000);
      write_csr(CSR_FOG_END, 64'd5000);
      write_csr(CSR_AMBIENT, 64'd256);
      write_csr(CSR_BAND_LIMITS, 64'h8000_0000_0100_0200);
      write_csr(CSR_BAND_COLOURS, 64'hF800_07E0_001F_FFFF);
      write_csr(CSR_SKY_COLOUR, 64'hA5C3E1);
      write_csr(CSR_FOG_COLOUR, 64'h123456);
      write_csr(CSR_LIGHT_DIR, 64'h7FFF_7FFF_7FFF);
      for (int d = 0; d < 6; d++) begin
         q = rnd_request();
         q.ray_distance = (d == 0) ? 20'd1000 : (d == 1) ? 20'd1001 : (d == 2) ? 20'd5000 :
                          (d == 3) ? 20'd5001 : (d == 4) ? 20'd0 : 20'd3000;
         q.centre_height = 24'(d * 24'h10000) - 24'h20000;
         send_request(q, d != 5);
      end
      drain();
      write_csr(CSR_AMBIENT, 64'h1FF);
      write_csr(CSR_LIGHT_DIR, 64'h8000_8000_8000);
      for (int d = 0; d < 4; d++) begin
         q = rnd_request();
         send_request(q, 0);
      end
      drain();

      // random phases with bursty sender
      for (int ph = 0; ph < 8; ph++) begin
         random_setting(ph % 5);
         for (int n = 0; n < 140; ) begin
            burst = $urandom_range(1, 30);
            for (int b = 0; b < burst && n < 140; b++, n++)
               send_request(rnd_request(), b != burst - 1 && n != 139);
            if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 12)) @(negedge clock);
         end
         drain();
      end

      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
